/* rtl/core/rhc_pkg.sv */
package rhc_pkg;

	typedef struct packed {
		logic       cmd;
		logic [8:0] hue_or_red;
		logic [8:0] sat_or_green;
		logic [8:0] val_or_blue;
	} pix_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [8:0] hue_deg;
		logic [6:0] saturation_pct;
		logic [6:0] brightness_pct;
		logic       range_error;
	} res_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [8:0] hue;
		logic [6:0] sat;
		logic [6:0] val;
	} hsv_t;

	localparam logic CMD_HSV2RGB = 1'b0;
	localparam logic CMD_RGB2HSV = 1'b1;

	localparam logic [8:0] HUE_FULL = 9'd360;
	localparam logic [8:0] PCT_MAX  = 9'd100;
	localparam logic [8:0] CH_MAX   = 9'd255;

	// floor(x / c) == (x * ceil(2^k / c)) >> k when k >= log2(x range) + ceil(log2 c);
	// the 255 scale is folded into each constant (255/100 = 51/20 and so on)
	localparam int LV_SHIFT = 18;
	localparam logic [19:0] LV_MUL =
		20'(((64'd1 << LV_SHIFT) + 64'd19) / 64'd20 * 64'd51);
	localparam int LP_SHIFT = 30;
	localparam logic [24:0] LP_MUL =
		25'(((64'd1 << LP_SHIFT) + 64'd1999) / 64'd2000 * 64'd51);
	localparam int LQ_SHIFT = 40;
	localparam logic [28:0] LQ_MUL =
		29'(((64'd1 << LQ_SHIFT) + 64'd39999) / 64'd40000 * 64'd17);
	localparam int VB_SHIFT = 19;
	localparam logic [17:0] VB_MUL =
		18'(((64'd1 << VB_SHIFT) + 64'd50) / 64'd51 * 64'd20);

endpackage

/* rtl/core/rhc_hsv2rgb.sv */
module rhc_hsv2rgb (
	input  logic          clk,
	input  logic          en,
	input  rhc_pkg::hsv_t hsv,
	output rhc_pkg::rgb_t rgb
);

	// stage A: sector and offset within sector
	logic [8:0] hn;
	logic [2:0] sec;
	logic [8:0] base;
	logic [8:0] fdiff;

	always_comb begin
		hn = (hsv.hue >= rhc_pkg::HUE_FULL) ? 9'd0 : hsv.hue;
		if (hn < 9'd60) begin
			sec = 3'd0; base = 9'd0;
		end else if (hn < 9'd120) begin
			sec = 3'd1; base = 9'd60;
		end else if (hn < 9'd180) begin
			sec = 3'd2; base = 9'd120;
		end else if (hn < 9'd240) begin
			sec = 3'd3; base = 9'd180;
		end else if (hn < 9'd300) begin
			sec = 3'd4; base = 9'd240;
		end else begin
			sec = 3'd5; base = 9'd300;
		end
		fdiff = hn - base;
	end

	logic [2:0] sec_s2;
	logic [5:0] f_s2;
	logic [6:0] sat_s2, val_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sec_s2 <= sec;
			f_s2   <= fdiff[5:0];
			sat_s2 <= hsv.sat;
			val_s2 <= hsv.val;
		end
	end

	// stage B: first products
	logic [13:0] a_b;
	logic [12:0] pf_b, pg_b;

	always_comb begin
		a_b  = val_s2 * (7'd100 - sat_s2);
		pf_b = sat_s2 * f_s2;
		pg_b = sat_s2 * (6'd60 - f_s2);
	end

	logic [2:0]  sec_s3;
	logic [6:0]  val_s3;
	logic        grey_s3;
	logic [13:0] a_s3;
	logic [12:0] pf_s3, pg_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sec_s3  <= sec_s2;
			val_s3  <= val_s2;
			grey_s3 <= (sat_s2 == 7'd0);
			a_s3    <= a_b;
			pf_s3   <= pf_b;
			pg_s3   <= pg_b;
		end
	end

	// stage C: level numerators and the v and p levels
	logic [19:0] bq_c, bt_c;
	logic [38:0] mp_c;
	logic [26:0] mv_c;

	always_comb begin
		bq_c = val_s3 * (13'd6000 - pf_s3);
		bt_c = val_s3 * (13'd6000 - pg_s3);
		mp_c = a_s3 * rhc_pkg::LP_MUL;
		mv_c = val_s3 * rhc_pkg::LV_MUL;
	end

	logic [2:0]  sec_s4;
	logic        grey_s4;
	logic [7:0]  lv_s4, lp_s4;
	logic [19:0] bq_s4, bt_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sec_s4  <= sec_s3;
			grey_s4 <= grey_s3;
			lv_s4   <= mv_c[rhc_pkg::LV_SHIFT +: 8];
			lp_s4   <= mp_c[rhc_pkg::LP_SHIFT +: 8];
			bq_s4   <= bq_c;
			bt_s4   <= bt_c;
		end
	end

	// stage D: q and t levels, then place by sector
	logic [48:0] mq_d, mt_d;
	logic [7:0]  lq, lt;
	rhc_pkg::rgb_t sel;

	always_comb begin
		mq_d = bq_s4 * rhc_pkg::LQ_MUL;
		mt_d = bt_s4 * rhc_pkg::LQ_MUL;
		lq   = mq_d[rhc_pkg::LQ_SHIFT +: 8];
		lt   = mt_d[rhc_pkg::LQ_SHIFT +: 8];
		if (grey_s4) begin
			sel = '{red: lv_s4, green: lv_s4, blue: lv_s4};
		end else begin
			case (sec_s4)
				3'd0: sel = '{red: lv_s4, green: lt,    blue: lp_s4};
				3'd1: sel = '{red: lq,    green: lv_s4, blue: lp_s4};
				3'd2: sel = '{red: lp_s4, green: lv_s4, blue: lt};
				3'd3: sel = '{red: lp_s4, green: lq,    blue: lv_s4};
				3'd4: sel = '{red: lt,    green: lp_s4, blue: lv_s4};
				default: sel = '{red: lv_s4, green: lp_s4, blue: lq};
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgb <= sel;
		end
	end

endmodule

/* rtl/core/rhc_rgb2hsv.sv */
module rhc_rgb2hsv (
	input  logic          clk,
	input  logic          en,
	input  rhc_pkg::rgb_t rgb,
	output rhc_pkg::hsv_t hsv
);

	// one restoring step: shift in a dividend bit, subtract when it fits
	function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nb,
		input logic [7:0] dvs);
		logic [8:0] t;
		begin
			t = {rem, nb};
			if (t >= {1'b0, dvs}) begin
				div_step = {1'b1, 8'(t - {1'b0, dvs})};
			end else begin
				div_step = {1'b0, t[7:0]};
			end
		end
	endfunction

	// stage A: extremes and hue numerator
	logic [7:0]  mx, mn, d;
	logic [16:0] num;

	always_comb begin
		mx = (rgb.red > rgb.green) ? rgb.red : rgb.green;
		mx = (mx > rgb.blue) ? mx : rgb.blue;
		mn = (rgb.red < rgb.green) ? rgb.red : rgb.green;
		mn = (mn < rgb.blue) ? mn : rgb.blue;
		d  = mx - mn;
		if (rgb.red == mx) begin
			if (rgb.green >= rgb.blue) begin
				num = 17'd60 * 17'(rgb.green - rgb.blue);
			end else begin
				num = 17'd360 * 17'(d) - 17'd60 * 17'(rgb.blue - rgb.green);
			end
		end else if (rgb.green == mx) begin
			num = 17'd120 * 17'(d) + 17'd60 * 17'(rgb.blue) - 17'd60 * 17'(rgb.red);
		end else begin
			num = 17'd240 * 17'(d) + 17'd60 * 17'(rgb.red) - 17'd60 * 17'(rgb.green);
		end
	end

	logic [16:0] num_s2;
	logic [14:0] x_s2;
	logic [7:0]  d_s2, mx_s2;
	logic        grey_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2  <= num;
			x_s2    <= 15'd100 * 15'(d);
			d_s2    <= d;
			mx_s2   <= mx;
			grey_s2 <= (d == 8'd0);
		end
	end

	// stage B: brightness, hue bits 8..6, saturation bits 6..4
	logic [25:0] mb_b;
	logic [7:0]  rh_b, rs_b;
	logic [2:0]  qh_b, qs_b;
	logic [8:0]  st_b;

	always_comb begin
		mb_b = mx_s2 * rhc_pkg::VB_MUL;
		rh_b = num_s2[16:9];
		rs_b = x_s2[14:7];
		for (int i = 2; i >= 0; i--) begin
			st_b    = div_step(rh_b, num_s2[6 + i], d_s2);
			qh_b[i] = st_b[8];
			rh_b    = st_b[7:0];
			st_b    = div_step(rs_b, x_s2[4 + i], mx_s2);
			qs_b[i] = st_b[8];
			rs_b    = st_b[7:0];
		end
	end

	logic [7:0] rh_s3, rs_s3, d_s3, mx_s3;
	logic [2:0] qh_s3, qs_s3;
	logic [5:0] num_s3;
	logic [3:0] x_s3;
	logic [6:0] vb_s3;
	logic       grey_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			rh_s3   <= rh_b;
			rs_s3   <= rs_b;
			qh_s3   <= qh_b;
			qs_s3   <= qs_b;
			num_s3  <= num_s2[5:0];
			x_s3    <= x_s2[3:0];
			d_s3    <= d_s2;
			mx_s3   <= mx_s2;
			vb_s3   <= mb_b[rhc_pkg::VB_SHIFT +: 7];
			grey_s3 <= grey_s2;
		end
	end

	// stage C: hue bits 5..3, saturation bits 3..1
	logic [7:0] rh_c, rs_c;
	logic [2:0] qh_c, qs_c;
	logic [8:0] st_c;

	always_comb begin
		rh_c = rh_s3;
		rs_c = rs_s3;
		for (int i = 2; i >= 0; i--) begin
			st_c    = div_step(rh_c, num_s3[3 + i], d_s3);
			qh_c[i] = st_c[8];
			rh_c    = st_c[7:0];
			st_c    = div_step(rs_c, x_s3[1 + i], mx_s3);
			qs_c[i] = st_c[8];
			rs_c    = st_c[7:0];
		end
	end

	logic [7:0] rh_s4, rs_s4, d_s4, mx_s4;
	logic [5:0] qh_s4, qs_s4;
	logic [2:0] num_s4;
	logic       x_s4;
	logic [6:0] vb_s4;
	logic       grey_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			rh_s4   <= rh_c;
			rs_s4   <= rs_c;
			qh_s4   <= {qh_s3, qh_c};
			qs_s4   <= {qs_s3, qs_c};
			num_s4  <= num_s3[2:0];
			x_s4    <= x_s3[0];
			d_s4    <= d_s3;
			mx_s4   <= mx_s3;
			vb_s4   <= vb_s3;
			grey_s4 <= grey_s3;
		end
	end

	// stage D: hue bits 2..0, last saturation bit
	logic [7:0] rh_d;
	logic [2:0] qh_d;
	logic [8:0] st_d;
	logic [8:0] ss_d;

	always_comb begin
		rh_d = rh_s4;
		for (int i = 2; i >= 0; i--) begin
			st_d    = div_step(rh_d, num_s4[i], d_s4);
			qh_d[i] = st_d[8];
			rh_d    = st_d[7:0];
		end
		ss_d = div_step(rs_s4, x_s4, mx_s4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hsv.hue <= grey_s4 ? 9'd0 : {qh_s4, qh_d};
			hsv.sat <= grey_s4 ? 7'd0 : {qs_s4, ss_d[8]};
			hsv.val <= vb_s4;
		end
	end

endmodule

/* rtl/core/rgb_hsv_color_converter.sv */
// Pixel color converter between hue/saturation/brightness and RGB. The cmd field picks
// the direction; the input triple is echoed and the converted triple is returned, with
// range_error set and all else zero when a component is out of range. The datapath is a
// five-stage pipeline under one shared enable: a pixel transfers on every clock while the
// result side takes results, and each result is offered when its pixel reaches the last
// stage, held back by any stall on the result side. The depth is set by the 9-bit hue
// quotient, worked three bits per stage.
module rgb_hsv_color_converter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pix_valid,
	output logic          pix_ready,
	input  rhc_pkg::pix_t pix,
	output logic          res_valid,
	input  logic          res_ready,
	output rhc_pkg::res_t res
);

	typedef struct packed {
		logic       cmd;
		logic       err;
		logic [8:0] a;
		logic [8:0] b;
		logic [8:0] c;
	} meta_t;

	logic  en;
	logic  v_s1, v_s2, v_s3, v_s4, v_s5;
	meta_t in_meta;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5;
	rhc_pkg::rgb_t rgb_out;
	rhc_pkg::hsv_t hsv_out;

	// advance the whole pipe whenever the output slot is free or drains
	assign en        = !v_s5 || res_ready;
	assign pix_ready = en;
	assign res_valid = v_s5;

	always_comb begin
		in_meta.cmd = pix.cmd;
		in_meta.a   = pix.hue_or_red;
		in_meta.b   = pix.sat_or_green;
		in_meta.c   = pix.val_or_blue;
		if (pix.cmd == rhc_pkg::CMD_HSV2RGB) begin
			in_meta.err = (pix.hue_or_red > rhc_pkg::HUE_FULL) ||
				(pix.sat_or_green > rhc_pkg::PCT_MAX) || (pix.val_or_blue > rhc_pkg::PCT_MAX);
		end else begin
			in_meta.err = (pix.hue_or_red > rhc_pkg::CH_MAX) ||
				(pix.sat_or_green > rhc_pkg::CH_MAX) || (pix.val_or_blue > rhc_pkg::CH_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= in_meta;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
		end
	end

	rhc_hsv2rgb u_hsv2rgb (
		.clk (clk),
		.en  (en),
		.hsv ('{hue: meta_s1.a, sat: meta_s1.b[6:0], val: meta_s1.c[6:0]}),
		.rgb (rgb_out)
	);

	rhc_rgb2hsv u_rgb2hsv (
		.clk (clk),
		.en  (en),
		.rgb ('{red: meta_s1.a[7:0], green: meta_s1.b[7:0], blue: meta_s1.c[7:0]}),
		.hsv (hsv_out)
	);

	always_comb begin
		res = '0;
		if (meta_s5.err) begin
			res.range_error = 1'b1;
		end else if (meta_s5.cmd == rhc_pkg::CMD_HSV2RGB) begin
			res.red            = rgb_out.red;
			res.green          = rgb_out.green;
			res.blue           = rgb_out.blue;
			res.hue_deg        = meta_s5.a;
			res.saturation_pct = meta_s5.b[6:0];
			res.brightness_pct = meta_s5.c[6:0];
		end else begin
			res.red            = meta_s5.a[7:0];
			res.green          = meta_s5.b[7:0];
			res.blue           = meta_s5.c[7:0];
			res.hue_deg        = hsv_out.hue;
			res.saturation_pct = hsv_out.sat;
			res.brightness_pct = hsv_out.val;
		end
	end

endmodule
